@@ src/kmh_pkg.sv @@
// Shared types, constants and helpers for the key matrix HID event engine.
package kmh_pkg;

    // Matrix size defaults and fixed field widths
    localparam int ROWS_DEF     = 4;
    localparam int COLS_DEF     = 3;
    localparam int QUEUE_DEPTH  = 2;
    localparam int KEYS_W       = 12;
    localparam int AXIS_W       = 10;
    localparam int ACT_W        = 9;
    localparam int POS_IDX_W    = 4;
    localparam int KEYMAP_LO_W  = 63;
    localparam int KEYMAP_HI_W  = 45;
    localparam int KEYMAP_W     = KEYMAP_LO_W + KEYMAP_HI_W;
    localparam int CFG_DATA_W   = 63;
    localparam int CFG_IDX_W    = 3;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 32;
    localparam int KIND_W       = 3;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_NONE     = 9'h000;
    localparam logic [ACT_W-1:0] ACT_TEXT_LO  = 9'h020;
    localparam logic [ACT_W-1:0] ACT_TEXT_HI  = 9'h080;
    localparam logic [ACT_W-1:0] ACT_MOUSE    = 9'h100;
    localparam logic [ACT_W-1:0] ACT_WHEEL_UP = 9'h103;
    localparam logic [ACT_W-1:0] ACT_WHEEL_DN = 9'h104;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEYMAP_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEYMAP_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_SHIFT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_TRIG  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_COOL  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd7;

    // Register reset values
    localparam logic [AXIS_W-1:0] DEADZONE_RST    = 10'd25;
    localparam logic [2:0]        SCALE_SHIFT_RST = 3'd4;
    localparam logic [3:0]        WHEEL_TRIG_RST  = 4'd4;
    localparam logic [7:0]        WHEEL_COOL_RST  = 8'd12;
    localparam logic [AXIS_W-1:0] CENTER_RST      = 10'd512;

    // Event kinds
    localparam logic [KIND_W-1:0] KIND_KEY_PRESS   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_KEY_RELEASE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BTN_PRESS   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BTN_RELEASE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_WHEEL       = 3'd4;
    localparam logic [KIND_W-1:0] KIND_MOVE        = 3'd5;
    localparam logic [KIND_W-1:0] KIND_FRAME_END   = 3'd6;

    typedef struct packed {
        logic [KEYMAP_LO_W-1:0] keymap_low;
        logic [KEYMAP_HI_W-1:0] keymap_high;
        logic [AXIS_W-1:0]      dead_band;
        logic [2:0]             joy_scale_shift;
        logic [3:0]             wheel_arm;
        logic [7:0]             wheel_gap;
        logic [AXIS_W-1:0]      center_x;
        logic [AXIS_W-1:0]      center_y;
    } cfg_t;

    // One classified frame as it travels from front to back
    typedef struct packed {
        logic [KEYS_W-1:0] raw;
        logic              hit;
        logic              mv;
        logic [7:0]        mx;
        logic [7:0]        my;
    } frame_t;

    // Action of a position; undefined codes read as unused
    function automatic logic [ACT_W-1:0] action_at(cfg_t cfg, logic [POS_IDX_W-1:0] pos);
        logic [KEYMAP_W-1:0] map;
        logic [ACT_W-1:0]    a;
        map = {cfg.keymap_high, cfg.keymap_low};
        a   = map[ACT_W*pos +: ACT_W];
        return (a > ACT_WHEEL_DN) ? ACT_NONE : a;
    endfunction

endpackage

@@ src/kmh_cfg.sv @@
// Configuration register file of the key matrix HID event engine.
module kmh_cfg
    import kmh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  we,
    input  logic [CFG_IDX_W-1:0]  index,
    input  logic [CFG_DATA_W-1:0] data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // Decode the index and store the masked value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.keymap_low      <= '0;
            cfg_reg.keymap_high     <= '0;
            cfg_reg.dead_band       <= DEADZONE_RST;
            cfg_reg.joy_scale_shift <= SCALE_SHIFT_RST;
            cfg_reg.wheel_arm       <= WHEEL_TRIG_RST;
            cfg_reg.wheel_gap       <= WHEEL_COOL_RST;
            cfg_reg.center_x        <= CENTER_RST;
            cfg_reg.center_y        <= CENTER_RST;
        end
        else if (we)
        begin
            unique case (index)
                REG_KEYMAP_LOW:  cfg_reg.keymap_low      <= data[KEYMAP_LO_W-1:0];
                REG_KEYMAP_HIGH: cfg_reg.keymap_high     <= data[KEYMAP_HI_W-1:0];
                REG_DEADZONE:    cfg_reg.dead_band       <= data[AXIS_W-1:0];
                REG_SCALE_SHIFT: cfg_reg.joy_scale_shift <= data[2:0];
                REG_WHEEL_TRIG:  cfg_reg.wheel_arm       <= data[3:0];
                REG_WHEEL_COOL:  cfg_reg.wheel_gap       <= data[7:0];
                REG_CENTER_X:    cfg_reg.center_x        <= data[AXIS_W-1:0];
                REG_CENTER_Y:    cfg_reg.center_y        <= data[AXIS_W-1:0];
                default:         cfg_reg.center_y        <= cfg_reg.center_y;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/kmh_front.sv @@
// Front end: accepts scan frames, checks for mapped presses and scales joystick motion.
module kmh_front
    import kmh_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
)
(
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  cfg_t                  cfg,
    input  logic                  q_full,
    output logic                  push,
    output frame_t                push_data
);

    localparam int NPOS = ROWS * COLS;

    logic [KEYS_W-1:0] raw;
    logic [AXIS_W-1:0] joy_x;
    logic [AXIS_W-1:0] joy_y;
    logic [8:0]        ax_x;
    logic [8:0]        ax_y;
    logic              hit;

    // Deadzone test and scaled, saturated offset: {pass, value}
    function automatic logic [8:0] axis_eval(logic [AXIS_W-1:0] s, logic [AXIS_W-1:0] ctr,
                                             logic [AXIS_W-1:0] dz, logic [2:0] sh);
        logic [AXIS_W:0]   d;
        logic              neg;
        logic [AXIS_W:0]   mag_w;
        logic [AXIS_W-1:0] mag;
        logic [AXIS_W-1:0] shf;
        logic [7:0]        v;
        logic              pass;
        d     = {1'b0, s} - {1'b0, ctr};
        neg   = d[AXIS_W];
        mag_w = neg ? (~d + 11'd1) : d;
        mag   = mag_w[AXIS_W-1:0];
        pass  = (mag >= dz);
        shf   = mag >> sh;
        if (!neg)
            v = (shf > 10'd127) ? 8'd127 : shf[7:0];
        else
            v = (shf >= 10'd128) ? 8'h80 : (~shf[7:0] + 8'd1);
        return {pass, v};
    endfunction

    assign raw   = s_tdata[KEYS_W-1:0];
    assign joy_x = s_tdata[KEYS_W +: AXIS_W];
    assign joy_y = s_tdata[KEYS_W+AXIS_W +: AXIS_W];

    // Flag a closed switch on a mapped position
    always_comb
    begin
        hit = 1'b0;
        for (int p = 0; p < NPOS; p++)
        begin
            if (raw[p] && (action_at(cfg, POS_IDX_W'(p)) != ACT_NONE))
                hit = 1'b1;
        end
    end

    assign ax_x = axis_eval(joy_x, cfg.center_x, cfg.dead_band, cfg.joy_scale_shift);
    assign ax_y = axis_eval(joy_y, cfg.center_y, cfg.dead_band, cfg.joy_scale_shift);

    // Take a frame whenever the queue has room
    assign s_tready      = !q_full;
    assign push          = s_tvalid && !q_full;
    assign push_data.raw = raw;
    assign push_data.hit = hit;
    assign push_data.mv  = (ax_x[8] || ax_y[8]) && ((ax_x[7:0] != 8'd0) || (ax_y[7:0] != 8'd0));
    assign push_data.mx  = ax_x[7:0];
    assign push_data.my  = ax_y[7:0];

endmodule

@@ src/kmh_queue.sv @@
// Short frame queue between the front and back ends.
module kmh_queue
    import kmh_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  frame_t push_data,
    output logic   full,
    input  logic   pop,
    output frame_t pop_data,
    output logic   not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    frame_t           entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed frame
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue fill level beyond depth");

endmodule

@@ src/kmh_back.sv @@
// Back end: visits matrix positions, tracks key and wheel state and emits events.
module kmh_back
    import kmh_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              q_valid,
    input  frame_t            q_data,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [KIND_W-1:0] out_kind,
    output logic [7:0]        out_code,
    output logic [7:0]        out_mx,
    output logic [7:0]        out_my,
    output logic [1:0]        out_ws,
    output logic              out_lm,
    output logic              out_lt,
    output logic              out_ls,
    output logic              out_last
);

    localparam int NPOS = ROWS * COLS;
    localparam int PW   = (NPOS > 1) ? $clog2(NPOS) : 1;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW   = (COLS > 1) ? $clog2(COLS) : 1;
    localparam logic [PW-1:0] POS_LAST = PW'(NPOS - 1);
    localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_MOVE = 2'd2;
    localparam logic [1:0] S_END  = 2'd3;

    // Control state
    logic [1:0]      state_reg, state_next;
    logic            hid_active_reg, hid_active_next;
    logic [NPOS-1:0] held_reg, held_next;
    logic [3:0]      wcnt_reg [NPOS];
    logic [7:0]      wwait_reg [NPOS];
    logic [3:0]      wcnt_next;
    logic [7:0]      wwait_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [CW-1:0]   col_reg, col_next;
    logic            out_valid_reg, out_valid_next;

    // Frame payload
    logic [NPOS-1:0] raw_reg;
    logic            mv_reg;
    logic [7:0]      mx_reg;
    logic [7:0]      my_reg;
    logic            lm_reg, lm_next;
    logic            lt_reg, lt_next;
    logic            ls_reg, ls_next;

    // Output payload
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [7:0]        code_reg, code_next;
    logic [7:0]        omx_reg, omx_next;
    logic [7:0]        omy_reg, omy_next;
    logic [1:0]        ws_reg, ws_next;
    logic              olm_reg, olm_next;
    logic              olt_reg, olt_next;
    logic              ols_reg, ols_next;
    logic              last_reg, last_next;

    // Step signals
    logic             emit_ok;
    logic             out_load;
    logic             scan_do;
    logic             take;
    logic [COLS-1:0]  held_m [ROWS];
    logic             ghost;
    logic [ACT_W-1:0] act;
    logic [ACT_W-1:0] btn_idx;
    logic             mapped;
    logic             is_key;
    logic             is_wheel;
    logic             held_cur;
    logic             pr;
    logic [3:0]       cnt_cur;
    logic [3:0]       cnt_inc;
    logic [7:0]       wait_cur;
    logic [7:0]       wait_dec;
    logic             wheel_fire;
    logic             held_new;
    logic             step_emit;
    logic             cls_m;
    logic             cls_t;

    assign emit_ok = !out_valid_reg || out_ready;
    assign scan_do = (state_reg == S_SCAN) && emit_ok;
    assign take    = (state_reg == S_IDLE) && q_valid;
    assign q_pop   = take;

    // Matrix view of the held bits
    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            for (int c = 0; c < COLS; c++)
                held_m[r][c] = held_reg[r*COLS + c];
        end
    end

    // Fourth corner of a held rectangle
    always_comb
    begin
        ghost = 1'b0;
        for (int r2 = 0; r2 < ROWS; r2++)
        begin
            for (int c2 = 0; c2 < COLS; c2++)
            begin
                if ((row_reg != RW'(r2)) && (col_reg != CW'(c2)) && held_m[r2][col_reg]
                    && held_m[row_reg][c2] && held_m[r2][c2])
                    ghost = 1'b1;
            end
        end
    end

    // Evaluate the current position
    always_comb
    begin
        act        = action_at(cfg, POS_IDX_W'(pos_reg));
        btn_idx    = act - ACT_MOUSE;
        mapped     = (act != ACT_NONE);
        is_key     = (act < ACT_MOUSE);
        is_wheel   = (act >= ACT_WHEEL_UP);
        held_cur   = held_reg[pos_reg];
        pr         = raw_reg[pos_reg] && (held_cur || !ghost);
        cnt_cur    = wcnt_reg[pos_reg];
        wait_cur   = wwait_reg[pos_reg];
        wait_dec   = (wait_cur != 8'd0) ? (wait_cur - 8'd1) : 8'd0;
        cnt_inc    = (cnt_cur < cfg.wheel_arm) ? (cnt_cur + 4'd1) : cnt_cur;
        wheel_fire = pr && (cnt_inc >= cfg.wheel_arm) && (wait_dec == 8'd0);
        wcnt_next  = pr ? cnt_inc : 4'd0;
        wwait_next = wheel_fire ? cfg.wheel_gap : wait_dec;
        held_new   = mapped ? pr : held_cur;
        step_emit  = mapped && (is_wheel ? wheel_fire : (pr != held_cur));
        cls_m      = (act >= ACT_MOUSE);
        cls_t      = !cls_m && (act >= ACT_TEXT_LO) && (act < ACT_TEXT_HI);
    end

    // Sequencer and output register loading
    always_comb
    begin
        state_next      = state_reg;
        hid_active_next = hid_active_reg;
        held_next       = held_reg;
        pos_next        = pos_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        lm_next         = lm_reg;
        lt_next         = lt_reg;
        ls_next         = ls_reg;
        out_load        = 1'b0;
        kind_next       = KIND_FRAME_END;
        code_next       = 8'd0;
        omx_next        = 8'd0;
        omy_next        = 8'd0;
        ws_next         = 2'd0;
        olm_next        = 1'b0;
        olt_next        = 1'b0;
        ols_next        = 1'b0;
        last_next       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    lm_next  = 1'b0;
                    lt_next  = 1'b0;
                    ls_next  = 1'b0;
                    pos_next = '0;
                    row_next = '0;
                    col_next = '0;
                    if (hid_active_reg || q_data.hit)
                    begin
                        hid_active_next = 1'b1;
                        state_next      = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_END;
                    end
                end
            end
            S_SCAN:
            begin
                if (emit_ok)
                begin
                    held_next[pos_reg] = held_new;
                    if (held_new)
                    begin
                        lm_next = lm_reg || cls_m;
                        lt_next = lt_reg || cls_t;
                        ls_next = ls_reg || (!cls_m && !cls_t);
                    end
                    if (step_emit)
                    begin
                        out_load = 1'b1;
                        if (is_wheel)
                        begin
                            kind_next = KIND_WHEEL;
                            ws_next   = (act == ACT_WHEEL_UP) ? 2'b01 : 2'b11;
                        end
                        else if (is_key)
                        begin
                            kind_next = pr ? KIND_KEY_PRESS : KIND_KEY_RELEASE;
                            code_next = act[7:0];
                        end
                        else
                        begin
                            kind_next = pr ? KIND_BTN_PRESS : KIND_BTN_RELEASE;
                            code_next = btn_idx[7:0];
                        end
                    end
                    // Step to the next position in row-major order
                    pos_next = pos_reg + 1'b1;
                    if (col_reg == COL_LAST)
                    begin
                        col_next = '0;
                        row_next = row_reg + 1'b1;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                    if (pos_reg == POS_LAST)
                        state_next = S_MOVE;
                end
            end
            S_MOVE:
            begin
                if (!mv_reg)
                begin
                    state_next = S_END;
                end
                else if (emit_ok)
                begin
                    out_load   = 1'b1;
                    kind_next  = KIND_MOVE;
                    omx_next   = mx_reg;
                    omy_next   = my_reg;
                    state_next = S_END;
                end
            end
            S_END:
            begin
                if (emit_ok)
                begin
                    out_load   = 1'b1;
                    kind_next  = KIND_FRAME_END;
                    olm_next   = lm_reg;
                    olt_next   = lt_reg;
                    ols_next   = ls_reg;
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            hid_active_reg <= 1'b0;
            held_reg       <= '0;
            pos_reg        <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            out_valid_reg  <= 1'b0;
            for (int p = 0; p < NPOS; p++)
            begin
                wcnt_reg[p]  <= 4'd0;
                wwait_reg[p] <= 8'd0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            hid_active_reg <= hid_active_next;
            held_reg       <= held_next;
            pos_reg        <= pos_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            out_valid_reg  <= out_valid_next;
            // Wheel state changes only on wheel positions
            if (scan_do && mapped && is_wheel)
            begin
                wcnt_reg[pos_reg]  <= wcnt_next;
                wwait_reg[pos_reg] <= wwait_next;
            end
        end
    end

    // Frame and output payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            raw_reg <= q_data.raw[NPOS-1:0];
            mv_reg  <= q_data.mv;
            mx_reg  <= q_data.mx;
            my_reg  <= q_data.my;
        end
        lm_reg <= lm_next;
        lt_reg <= lt_next;
        ls_reg <= ls_next;
        if (out_load)
        begin
            kind_reg <= kind_next;
            code_reg <= code_next;
            omx_reg  <= omx_next;
            omy_reg  <= omy_next;
            ws_reg   <= ws_next;
            olm_reg  <= olm_next;
            olt_reg  <= olt_next;
            ols_reg  <= ols_next;
            last_reg <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = kind_reg;
    assign out_code  = code_reg;
    assign out_mx    = omx_reg;
    assign out_my    = omy_reg;
    assign out_ws    = ws_reg;
    assign out_lm    = olm_reg;
    assign out_lt    = olt_reg;
    assign out_ls    = ols_reg;
    assign out_last  = last_reg;

    a_active_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        hid_active_reg |=> hid_active_reg)
        else $error("hid_active cleared after being set");

    a_idle_no_held: assert property (@(posedge clk) disable iff (!rst_n)
        !hid_active_reg |-> (held_reg == '0))
        else $error("held position before first mapped press");

    a_scan_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> hid_active_reg)
        else $error("position scan while inactive");

    a_end_loads_last: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_END) && emit_ok) |=> ((state_reg == S_IDLE) && out_valid_reg
                                               && last_reg && (kind_reg == KIND_FRAME_END)))
        else $error("frame end item not loaded");

endmodule

@@ src/key_matrix_hid_event_engine_core.sv @@
// Top level of the key matrix HID event engine.
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        tdata: raw_keys, joy_x, joy_y
//  m_axis    out  m_axis_tvalid/tready        tdata: code, moves, wheel, leds; tuser kind
//  cfg       in   cfg_we                      cfg_index, cfg_data
//
// In the back end a frame is loaded in the idle state, then each matrix position is
// visited in turn, followed by the motion state and the frame end item.
// Frames before the first mapped press go from the load straight to the frame end item.
// The position sequencer sets the pace; up to two classified frames wait in
// the queue, and the front accepts one transfer per cycle while it has room.
// Reset clears all key, wheel and activity state; a stalled result holds the
// back end while the front keeps filling the queue.
module key_matrix_hid_event_engine_core
    import kmh_pkg::*;
#(
    parameter int ROWS   = ROWS_DEF,
    parameter int COLS   = COLS_DEF,
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // raw_keys[11:0], joy_x[21:12], joy_y[31:22]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // event_code[7:0], move_x[15:8], move_y[23:16], wheel_step[25:24],
    // led_mouse[26], led_text[27], led_special[28], zero[31:29]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // event_kind[2:0]
    output logic [KIND_W-1:0]      m_axis_tuser,
    output logic                   m_axis_tlast
);

    cfg_t        cfg;
    logic        q_full;
    logic        push;
    frame_t      push_data;
    logic        q_pop;
    frame_t      q_data;
    logic        q_valid;
    logic [7:0]  out_code;
    logic [7:0]  out_mx;
    logic [7:0]  out_my;
    logic [1:0]  out_ws;
    logic        out_lm;
    logic        out_lt;
    logic        out_ls;

    kmh_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    kmh_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .s_tdata   (s_axis_tdata),
        .cfg       (cfg),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    kmh_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .not_empty (q_valid)
    );

    kmh_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_code  (out_code),
        .out_mx    (out_mx),
        .out_my    (out_my),
        .out_ws    (out_ws),
        .out_lm    (out_lm),
        .out_lt    (out_lt),
        .out_ls    (out_ls),
        .out_last  (m_axis_tlast)
    );

    // Pack the result fields, lowest field first
    assign m_axis_tdata = {3'b000, out_ls, out_lt, out_lm, out_ws, out_my, out_mx, out_code};

endmodule
